### rtl/indexed_array_engine_top_defines.svh
// Assertion macros used by the checker of the indexed array engine.
// Depends on nothing; the including module must have aclk and aresetn.
`ifndef INDEXED_ARRAY_ENGINE_TOP_DEFINES_SVH
`define INDEXED_ARRAY_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IAE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IAE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/iae_pkg.sv
// Shared types and constants of the indexed array engine.
// Depends on nothing; used by the controller, datapath and top level.
package iae_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        ACT_INSERT    = 3'd0,
        ACT_REMOVE_AT = 3'd1,
        ACT_REMOVE_VAL = 3'd2,
        ACT_SORT      = 3'd3,
        ACT_LSEARCH   = 3'd4,
        ACT_BSEARCH   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_RANGE    = 2'd1,
        STS_FULL     = 2'd2,
        STS_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH,
        ST_INS_RD, ST_INS_WR,
        ST_RMI_RD, ST_RMI_WR,
        ST_RMV_RD, ST_RMV_WR,
        ST_SRT_PASS, ST_SRT_LOAD, ST_SRT_RD, ST_SRT_WR, ST_SRT_DONE,
        ST_BS_RD, ST_BS_CMP,
        ST_LS_RD, ST_LS_CMP
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LATCH,
        OP_INS_INIT, OP_RD_PREV, OP_SHIFT_UP, OP_INS_PUT,
        OP_RMI_INIT, OP_RD_NEXT, OP_SHIFT_DN, OP_DEC,
        OP_SCAN_INIT, OP_RD_PTR, OP_COMPACT, OP_RMV_DONE,
        OP_SRT_INIT, OP_RD_ZERO, OP_LOAD_CUR, OP_BUBBLE, OP_SRT_END,
        OP_BS_INIT, OP_RD_MID, OP_BS_LEFT, OP_BS_RIGHT,
        OP_LS_MATCH, OP_INC
    } op_t;

    typedef struct packed {
        op_t     op;
        logic    push;
        status_t status;
        logic    last;
        logic    use_fidx;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    idx_gt_cnt;
        logic    idx_ge_cnt;
        logic    full;
        logic    ptr_gt_idx;
        logic    ptr_next_lt_cnt;
        logic    ptr_lt_cnt;
        logic    ptr_le_end;
        logic    end_zero;
        logic    lo_lt_hi;
        logic    rd_eq_val;
        logic    val_lt_rd;
        logic    pend;
        logic    rmv_hit;
        logic    out_free;
    } sts_t;

endpackage

### rtl/indexed_array_engine_top.sv
// Top level of the indexed array engine: controller plus datapath.
// Depends on iae_pkg, iae_ctrl and iae_datapath.
//
//  channel  | ports                                          | role
//  ---------+------------------------------------------------+-----------------------
//  s_       | s_valid s_ready s_action s_index s_value       | one action per transfer
//  m_       | m_valid m_ready m_status m_found_index         | one or more results per
//           | m_element_count m_last                         | action, m_last on final
//
// One action at a time. The action is latched, then dispatched; then each entry move
// or scan step first reads the entry memory into a register, then uses the data:
// insert shifts the entries from the count down to the index up by one, remove at
// index shifts the later entries down, remove by value and linear search scan every
// entry, sort runs bubble passes, and binary search sorts first, then bisects.
// Reset clears the entry count, the output valid and the control state; entry contents stay undefined.
// Stalls: a waiting result in the output register blocks only the next result push, so the
// block can accept a new action and run it up to its first result push while m_valid is held.
module indexed_array_engine_top #(
    parameter int DEPTH      = iae_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = iae_pkg::DATA_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic [4:0]         s_index,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [3:0]         m_found_index,
    output logic [4:0]         m_element_count,
    output logic               m_last
);

    // command and status between the sequencer and the datapath
    iae_pkg::cmd_t cmd;
    iae_pkg::sts_t sts;

    iae_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // entry memory, pointers and the output register live here
    iae_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_action        (s_action),
        .s_index         (s_index),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_index   (m_found_index),
        .m_element_count (m_element_count),
        .m_last          (m_last),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

### rtl/iae_ctrl.sv
// Controller state machine of the indexed array engine.
// Depends on iae_pkg; drives commands into iae_datapath.
module iae_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  iae_pkg::sts_t sts,
    output iae_pkg::cmd_t cmd
);

    iae_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iae_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.op       = iae_pkg::OP_NOP;
        cmd.push     = 1'b0;
        cmd.status   = iae_pkg::STS_OK;
        cmd.last     = 1'b1;
        cmd.use_fidx = 1'b0;
        s_ready      = (state_reg == iae_pkg::ST_IDLE);
        case (state_reg)
            iae_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = iae_pkg::OP_LATCH;
                    state_next = iae_pkg::ST_DISPATCH;
                end
            end
            iae_pkg::ST_DISPATCH: begin
                case (sts.act)
                    iae_pkg::ACT_INSERT: begin
                        if (sts.idx_gt_cnt || sts.full) begin
                            if (sts.out_free) begin
                                cmd.push   = 1'b1;
                                cmd.status = sts.idx_gt_cnt ? iae_pkg::STS_RANGE
                                                            : iae_pkg::STS_FULL;
                                state_next = iae_pkg::ST_IDLE;
                            end
                        end else begin
                            cmd.op     = iae_pkg::OP_INS_INIT;
                            state_next = iae_pkg::ST_INS_RD;
                        end
                    end
                    iae_pkg::ACT_REMOVE_AT: begin
                        if (sts.idx_ge_cnt) begin
                            if (sts.out_free) begin
                                cmd.push   = 1'b1;
                                cmd.status = iae_pkg::STS_RANGE;
                                state_next = iae_pkg::ST_IDLE;
                            end
                        end else begin
                            cmd.op     = iae_pkg::OP_RMI_INIT;
                            state_next = iae_pkg::ST_RMI_RD;
                        end
                    end
                    iae_pkg::ACT_REMOVE_VAL: begin
                        cmd.op     = iae_pkg::OP_SCAN_INIT;
                        state_next = iae_pkg::ST_RMV_RD;
                    end
                    iae_pkg::ACT_SORT, iae_pkg::ACT_BSEARCH: begin
                        cmd.op     = iae_pkg::OP_SRT_INIT;
                        state_next = iae_pkg::ST_SRT_PASS;
                    end
                    iae_pkg::ACT_LSEARCH: begin
                        cmd.op     = iae_pkg::OP_SCAN_INIT;
                        state_next = iae_pkg::ST_LS_RD;
                    end
                    default: begin
                        if (sts.out_free) begin
                            cmd.push   = 1'b1;
                            state_next = iae_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            iae_pkg::ST_INS_RD: begin
                if (sts.ptr_gt_idx) begin
                    cmd.op     = iae_pkg::OP_RD_PREV;
                    state_next = iae_pkg::ST_INS_WR;
                end else if (sts.out_free) begin
                    cmd.op     = iae_pkg::OP_INS_PUT;
                    cmd.push   = 1'b1;
                    state_next = iae_pkg::ST_IDLE;
                end
            end
            iae_pkg::ST_INS_WR: begin
                cmd.op     = iae_pkg::OP_SHIFT_UP;
                state_next = iae_pkg::ST_INS_RD;
            end
            iae_pkg::ST_RMI_RD: begin
                if (sts.ptr_next_lt_cnt) begin
                    cmd.op     = iae_pkg::OP_RD_NEXT;
                    state_next = iae_pkg::ST_RMI_WR;
                end else if (sts.out_free) begin
                    cmd.op     = iae_pkg::OP_DEC;
                    cmd.push   = 1'b1;
                    state_next = iae_pkg::ST_IDLE;
                end
            end
            iae_pkg::ST_RMI_WR: begin
                cmd.op     = iae_pkg::OP_SHIFT_DN;
                state_next = iae_pkg::ST_RMI_RD;
            end
            iae_pkg::ST_RMV_RD: begin
                if (sts.ptr_lt_cnt) begin
                    cmd.op     = iae_pkg::OP_RD_PTR;
                    state_next = iae_pkg::ST_RMV_WR;
                end else if (sts.out_free) begin
                    cmd.op     = iae_pkg::OP_RMV_DONE;
                    cmd.push   = 1'b1;
                    cmd.status = sts.rmv_hit ? iae_pkg::STS_OK : iae_pkg::STS_NOTFOUND;
                    state_next = iae_pkg::ST_IDLE;
                end
            end
            iae_pkg::ST_RMV_WR: begin
                cmd.op     = iae_pkg::OP_COMPACT;
                state_next = iae_pkg::ST_RMV_RD;
            end
            iae_pkg::ST_SRT_PASS: begin
                if (sts.end_zero) begin
                    state_next = iae_pkg::ST_SRT_DONE;
                end else begin
                    cmd.op     = iae_pkg::OP_RD_ZERO;
                    state_next = iae_pkg::ST_SRT_LOAD;
                end
            end
            iae_pkg::ST_SRT_LOAD: begin
                cmd.op     = iae_pkg::OP_LOAD_CUR;
                state_next = iae_pkg::ST_SRT_RD;
            end
            iae_pkg::ST_SRT_RD: begin
                if (sts.ptr_le_end) begin
                    cmd.op     = iae_pkg::OP_RD_PTR;
                    state_next = iae_pkg::ST_SRT_WR;
                end else begin
                    cmd.op     = iae_pkg::OP_SRT_END;
                    state_next = iae_pkg::ST_SRT_PASS;
                end
            end
            iae_pkg::ST_SRT_WR: begin
                cmd.op     = iae_pkg::OP_BUBBLE;
                state_next = iae_pkg::ST_SRT_RD;
            end
            iae_pkg::ST_SRT_DONE: begin
                if (sts.act == iae_pkg::ACT_BSEARCH) begin
                    cmd.op     = iae_pkg::OP_BS_INIT;
                    state_next = iae_pkg::ST_BS_RD;
                end else if (sts.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = iae_pkg::ST_IDLE;
                end
            end
            iae_pkg::ST_BS_RD: begin
                if (sts.lo_lt_hi) begin
                    cmd.op     = iae_pkg::OP_RD_MID;
                    state_next = iae_pkg::ST_BS_CMP;
                end else if (sts.out_free) begin
                    cmd.push   = 1'b1;
                    cmd.status = iae_pkg::STS_NOTFOUND;
                    state_next = iae_pkg::ST_IDLE;
                end
            end
            iae_pkg::ST_BS_CMP: begin
                if (sts.rd_eq_val) begin
                    // keep reading the hit entry while the output register is busy
                    cmd.op = iae_pkg::OP_RD_MID;
                    if (sts.out_free) begin
                        cmd.push     = 1'b1;
                        cmd.use_fidx = 1'b1;
                        state_next   = iae_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.op     = sts.val_lt_rd ? iae_pkg::OP_BS_LEFT : iae_pkg::OP_BS_RIGHT;
                    state_next = iae_pkg::ST_BS_RD;
                end
            end
            iae_pkg::ST_LS_RD: begin
                if (sts.ptr_lt_cnt) begin
                    cmd.op     = iae_pkg::OP_RD_PTR;
                    state_next = iae_pkg::ST_LS_CMP;
                end else if (sts.out_free) begin
                    cmd.push     = 1'b1;
                    cmd.status   = sts.pend ? iae_pkg::STS_OK : iae_pkg::STS_NOTFOUND;
                    cmd.use_fidx = sts.pend;
                    state_next   = iae_pkg::ST_IDLE;
                end
            end
            iae_pkg::ST_LS_CMP: begin
                if (!sts.rd_eq_val) begin
                    cmd.op     = iae_pkg::OP_INC;
                    state_next = iae_pkg::ST_LS_RD;
                end else if (!sts.pend || sts.out_free) begin
                    // release the previous match, now known not to be the last
                    cmd.op       = iae_pkg::OP_LS_MATCH;
                    cmd.push     = sts.pend;
                    cmd.last     = 1'b0;
                    cmd.use_fidx = 1'b1;
                    state_next   = iae_pkg::ST_LS_RD;
                end
            end
            default: begin
                state_next = iae_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/iae_datapath.sv
// Datapath of the indexed array engine: entry memory, count, pointers, output register.
// Depends on iae_pkg; commanded by iae_ctrl.
module iae_datapath #(
    parameter int DEPTH      = iae_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = iae_pkg::DATA_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [2:0]          s_action,
    input  logic [4:0]          s_index,
    input  logic signed [31:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [3:0]          m_found_index,
    output logic [4:0]          m_element_count,
    output logic                m_last,
    input  iae_pkg::cmd_t       cmd,
    output iae_pkg::sts_t       sts
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    logic signed [DATA_WIDTH-1:0] mem [DEPTH];

    iae_pkg::action_t             act_reg;
    logic [4:0]                   idx_reg;
    logic signed [DATA_WIDTH-1:0] val_reg, cur_reg, rdata_reg;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [CW-1:0]                ptr_reg, end_reg, lo_reg, hi_reg, fidx_reg;
    logic                         pend_reg;
    logic                         m_valid_reg;
    logic [1:0]                   status_reg;
    logic [3:0]                   fidx_out_reg;
    logic [4:0]                   count_out_reg;
    logic                         last_reg;

    logic signed [63:0]           val_ext;
    logic [CW:0]                  mid_sum;
    logic [CW-1:0]                mid;
    logic [CW-1:0]                rd_addr;
    logic [CW-1:0]                wr_addr;
    logic signed [DATA_WIDTH-1:0] wr_data;
    logic                         wr_en;

    assign val_ext = {{32{s_value[31]}}, s_value};
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CW + 1)'(1);
    assign mid     = mid_sum[CW:1];

    always_comb begin
        case (cmd.op)
            iae_pkg::OP_INS_PUT: cnt_next = cnt_reg + CW'(1);
            iae_pkg::OP_DEC:     cnt_next = cnt_reg - CW'(1);
            iae_pkg::OP_RMV_DONE: cnt_next = lo_reg;
            default:             cnt_next = cnt_reg;
        endcase
    end

    always_comb begin
        case (cmd.op)
            iae_pkg::OP_RD_PREV: rd_addr = ptr_reg - CW'(1);
            iae_pkg::OP_RD_NEXT: rd_addr = ptr_reg + CW'(1);
            iae_pkg::OP_RD_ZERO: rd_addr = '0;
            iae_pkg::OP_RD_MID:  rd_addr = mid;
            default:             rd_addr = ptr_reg;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = rdata_reg;
        case (cmd.op)
            iae_pkg::OP_SHIFT_UP, iae_pkg::OP_SHIFT_DN: begin
                wr_en = 1'b1;
            end
            iae_pkg::OP_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = CW'(idx_reg);
                wr_data = val_reg;
            end
            iae_pkg::OP_COMPACT: begin
                wr_en   = (rdata_reg != val_reg);
                wr_addr = lo_reg;
            end
            iae_pkg::OP_BUBBLE: begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg - CW'(1);
                wr_data = (rdata_reg < cur_reg) ? rdata_reg : cur_reg;
            end
            iae_pkg::OP_SRT_END: begin
                wr_en   = 1'b1;
                wr_addr = end_reg;
                wr_data = cur_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        rdata_reg <= mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            iae_pkg::OP_LATCH: begin
                act_reg <= iae_pkg::action_t'(s_action);
                idx_reg <= s_index;
                val_reg <= val_ext[DATA_WIDTH-1:0];
            end
            iae_pkg::OP_INS_INIT:  ptr_reg <= cnt_reg;
            iae_pkg::OP_SHIFT_UP:  ptr_reg <= ptr_reg - CW'(1);
            iae_pkg::OP_RMI_INIT:  ptr_reg <= CW'(idx_reg);
            iae_pkg::OP_SHIFT_DN:  ptr_reg <= ptr_reg + CW'(1);
            iae_pkg::OP_SCAN_INIT: begin
                ptr_reg  <= '0;
                lo_reg   <= '0;
                pend_reg <= 1'b0;
            end
            iae_pkg::OP_COMPACT: begin
                ptr_reg <= ptr_reg + CW'(1);
                if (rdata_reg != val_reg) begin
                    lo_reg <= lo_reg + CW'(1);
                end
            end
            iae_pkg::OP_SRT_INIT:  end_reg <= (cnt_reg == '0) ? '0 : cnt_reg - CW'(1);
            iae_pkg::OP_RD_ZERO:   ptr_reg <= CW'(1);
            iae_pkg::OP_LOAD_CUR:  cur_reg <= rdata_reg;
            iae_pkg::OP_BUBBLE: begin
                ptr_reg <= ptr_reg + CW'(1);
                if (!(rdata_reg < cur_reg)) begin
                    cur_reg <= rdata_reg;
                end
            end
            iae_pkg::OP_SRT_END:   end_reg <= end_reg - CW'(1);
            iae_pkg::OP_BS_INIT: begin
                lo_reg <= '0;
                hi_reg <= cnt_reg;
            end
            iae_pkg::OP_RD_MID:    fidx_reg <= mid;
            iae_pkg::OP_BS_LEFT:   hi_reg <= fidx_reg;
            iae_pkg::OP_BS_RIGHT:  lo_reg <= fidx_reg + CW'(1);
            iae_pkg::OP_LS_MATCH: begin
                fidx_reg <= ptr_reg;
                pend_reg <= 1'b1;
                ptr_reg  <= ptr_reg + CW'(1);
            end
            iae_pkg::OP_INC:       ptr_reg <= ptr_reg + CW'(1);
            default: begin
            end
        endcase
    end

    // entry count and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            status_reg    <= cmd.status;
            fidx_out_reg  <= cmd.use_fidx ? 4'(fidx_reg) : 4'd0;
            count_out_reg <= 5'(cnt_next);
            last_reg      <= cmd.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_found_index   = fidx_out_reg;
    assign m_element_count = count_out_reg;
    assign m_last          = last_reg;

    always_comb begin
        sts.act             = act_reg;
        sts.idx_gt_cnt      = CMPW'(idx_reg) > CMPW'(cnt_reg);
        sts.idx_ge_cnt      = CMPW'(idx_reg) >= CMPW'(cnt_reg);
        sts.full            = (cnt_reg == CW'(DEPTH));
        sts.ptr_gt_idx      = CMPW'(ptr_reg) > CMPW'(idx_reg);
        sts.ptr_next_lt_cnt = ({1'b0, ptr_reg} + (CW + 1)'(1)) < {1'b0, cnt_reg};
        sts.ptr_lt_cnt      = ptr_reg < cnt_reg;
        sts.ptr_le_end      = ptr_reg <= end_reg;
        sts.end_zero        = (end_reg == '0);
        sts.lo_lt_hi        = lo_reg < hi_reg;
        sts.rd_eq_val       = (rdata_reg == val_reg);
        sts.val_lt_rd       = (val_reg < rdata_reg);
        sts.pend            = pend_reg;
        sts.rmv_hit         = (lo_reg != cnt_reg);
        sts.out_free        = !m_valid_reg || m_ready;
    end

endmodule

### rtl/iae_checker.sv
// Port-level checker of the indexed array engine, bound to the top level.
// Depends on iae_pkg and indexed_array_engine_top_defines.svh.
`include "indexed_array_engine_top_defines.svh"

module iae_checker #(
    parameter int DEPTH = iae_pkg::DEPTH_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [3:0]  m_found_index,
    input logic [4:0]  m_element_count,
    input logic        m_last
);

    `IAE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_found_index) && $stable(m_element_count) && $stable(m_last), "result changed while stalled")
    `IAE_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "accepted twice in a row")
    `IAE_ASSERT_NOW(a_err_is_last, m_valid && (m_status != iae_pkg::STS_OK), m_last && (m_found_index == 4'd0), "error result not final or has a position")
    `IAE_ASSERT_NOW(a_count_bound, m_valid, 32'(m_element_count) <= DEPTH, "element count above capacity")

endmodule

bind indexed_array_engine_top iae_checker #(.DEPTH(DEPTH)) u_iae_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_found_index   (m_found_index),
    .m_element_count (m_element_count),
    .m_last          (m_last)
);
